// ===== hdl/csmt_pkg.sv =====
package csmt_pkg;

  // Table size and derived index widths.
  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  // Field widths of the input and result items.
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int MIN_W     = 60;
  localparam int HOUR_W    = 24;
  localparam int DAY_W     = 31;
  localparam int MON_W     = 12;
  localparam int WDAY_W    = 7;
  localparam int MINUTE_W  = 6;
  localparam int HOURV_W   = 5;
  localparam int MDAY_W    = 5;
  localparam int MONTH_W   = 4;
  localparam int WEEKDAY_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MATCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // One schedule entry as held in the mask store.
  typedef struct packed {
    logic [MIN_W-1:0]  minute_mask;
    logic [HOUR_W-1:0] hour_mask;
    logic [DAY_W-1:0]  day_mask;
    logic [MON_W-1:0]  month_mask;
    logic [WDAY_W-1:0] weekday_mask;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic wr_en;
    logic clr_en;
    logic ack_load;
    logic start;
    logic scan_en;
    logic emit_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] op;
    logic            out_free;
    logic            scan_done;
    logic            emit_last;
  } sts_t;

endpackage

// ===== hdl/csmt_if.sv =====
interface csmt_in_if import csmt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [SLOT_W-1:0]    slot;
  logic [MIN_W-1:0]     minute_mask;
  logic [HOUR_W-1:0]    hour_mask;
  logic [DAY_W-1:0]     day_mask;
  logic [MON_W-1:0]     month_mask;
  logic [WDAY_W-1:0]    weekday_mask;
  logic [MINUTE_W-1:0]  minute;
  logic [HOURV_W-1:0]   hour;
  logic [MDAY_W-1:0]    month_day;
  logic [MONTH_W-1:0]   month;
  logic [WEEKDAY_W-1:0] weekday;

  modport source (
    output valid, op, slot, minute_mask, hour_mask, day_mask, month_mask, weekday_mask,
    output minute, hour, month_day, month, weekday,
    input  ready
  );
  modport sink (
    input  valid, op, slot, minute_mask, hour_mask, day_mask, month_mask, weekday_mask,
    input  minute, hour, month_day, month, weekday,
    output ready
  );
endinterface

interface csmt_out_if import csmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              matched;
  logic [SLOT_W-1:0] task_slot;
  logic              last;

  modport source (output valid, matched, task_slot, last, input ready);
  modport sink (input valid, matched, task_slot, last, output ready);
endinterface

// ===== hdl/cron_schedule_match_table.sv =====
// Channel | Dir | Modport       | Item
// req_i   | in  | csmt_in_if    | op, slot, five masks, broken-down time
// rsp_o   | out | csmt_out_if   | matched, task_slot, last
//
// A write or clear item needs no scan; its acknowledge item is offered the next cycle.
// A match item scans the table one entry per cycle through the registered read port of the
// mask store, then emits one item per cycle while the output is not stalled.
// Reset clears the valid marks at once; no clearing pass follows.
// Results wait in an output register; a stalled output holds it, and a new item is taken
// only when the block is idle and that register is free or being taken.
module cron_schedule_match_table import csmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  csmt_in_if.sink    req_i,
  csmt_out_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  csmt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Table, scan and output datapath.
  csmt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== hdl/csmt_ctrl.sv =====
module csmt_ctrl import csmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  op_e    op;
  logic   accept;

  assign op = op_e'(sts_i.op);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.in_ready = (state_q == ST_IDLE) && sts_i.out_free;
    accept         = cmd_o.in_ready && sts_i.in_valid;
    case (op)
      OP_WRITE: cmd_o.wr_en  = accept;
      OP_CLEAR: cmd_o.clr_en = accept;
      OP_MATCH: cmd_o.start  = accept;
      default:  cmd_o.start  = 1'b0;
    endcase
    cmd_o.ack_load = cmd_o.wr_en || cmd_o.clr_en;
    cmd_o.scan_en  = (state_q == ST_SCAN);
    cmd_o.emit_en  = (state_q == ST_EMIT) && sts_i.out_free;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.emit_en && sts_i.emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/csmt_dp.sv =====
module csmt_dp import csmt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  csmt_in_if.sink    req_i,
  csmt_out_if.source rsp_o
);

  entry_t entry_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] ev_q;

  // Time of the current match item, already turned into bit positions.
  logic [MINUTE_W-1:0]  min_q;
  logic [HOURV_W-1:0]   hour_q;
  logic [MDAY_W-1:0]    mday_m1_q;
  logic                 mday_ok_q;
  logic [MONTH_W-1:0]   mon_m1_q;
  logic                 mon_ok_q;
  logic [WEEKDAY_W-1:0] wday_q;

  // Scan state.
  logic [CNT_W-1:0]       cnt_q;
  logic                   rd_pend_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic                   rd_ev_q;
  entry_t                 rd_entry_q;
  logic [NUM_ENTRIES-1:0] due_q;
  logic                   rd_en;
  logic                   hit;
  logic                   slot_ok;
  logic [IDX_W-1:0]       wr_idx;
  logic [IDX_W-1:0]       enc_idx;

  // Output register.
  logic              out_vld_q;
  logic              out_matched_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_last_q;
  logic              load;

  logic [MIN_W-1:0]  m_sh;
  logic [HOUR_W-1:0] h_sh;
  logic [DAY_W-1:0]  d_sh;
  logic [MON_W-1:0]  n_sh;
  logic [WDAY_W-1:0] w_sh;

  assign slot_ok = (32'(req_i.slot) < NUM_ENTRIES);
  assign wr_idx  = IDX_W'(req_i.slot);
  assign rd_en   = cmd_i.scan_en && (cnt_q < CNT_W'(NUM_ENTRIES));

  // Mask store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) begin
      entry_mem[wr_idx] <= '{minute_mask:  req_i.minute_mask,
                             hour_mask:    req_i.hour_mask,
                             day_mask:     req_i.day_mask,
                             month_mask:   req_i.month_mask,
                             weekday_mask: req_i.weekday_mask};
    end
    if (rd_en) begin
      rd_entry_q <= entry_mem[cnt_q[IDX_W-1:0]];
    end
  end

  // Valid marks, cleared at reset and by a clear item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
    end else if (cmd_i.clr_en) begin
      ev_q <= '0;
    end else if (cmd_i.wr_en && slot_ok) begin
      ev_q[wr_idx] <= 1'b1;
    end
  end

  // Capture the time of a match item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      min_q     <= req_i.minute;
      hour_q    <= req_i.hour;
      mday_m1_q <= req_i.month_day - MDAY_W'(1);
      mday_ok_q <= (req_i.month_day != '0);
      mon_m1_q  <= req_i.month - MONTH_W'(1);
      mon_ok_q  <= (req_i.month != '0);
      wday_q    <= req_i.weekday;
    end
  end

  // A shift past the top of a mask yields zero, so out of range times miss.
  always_comb begin
    m_sh = rd_entry_q.minute_mask >> min_q;
    h_sh = rd_entry_q.hour_mask >> hour_q;
    d_sh = rd_entry_q.day_mask >> mday_m1_q;
    n_sh = rd_entry_q.month_mask >> mon_m1_q;
    w_sh = rd_entry_q.weekday_mask >> wday_q;
    hit  = m_sh[0] && h_sh[0] && mday_ok_q && d_sh[0] && mon_ok_q && n_sh[0] && w_sh[0];
  end

  // Scan counter and read pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
      rd_ev_q   <= 1'b0;
    end else if (cmd_i.start) begin
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else if (rd_en) begin
      cnt_q     <= cnt_q + CNT_W'(1);
      rd_pend_q <= 1'b1;
      rd_idx_q  <= cnt_q[IDX_W-1:0];
      rd_ev_q   <= ev_q[cnt_q[IDX_W-1:0]];
    end else begin
      rd_pend_q <= 1'b0;
    end
  end

  // Due vector: filled during the scan, drained lowest slot first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q <= '0;
    end else if (cmd_i.start) begin
      due_q <= '0;
    end else if (cmd_i.scan_en && rd_pend_q && rd_ev_q && hit) begin
      due_q[rd_idx_q] <= 1'b1;
    end else if (cmd_i.emit_en) begin
      due_q <= due_q & (due_q - NUM_ENTRIES'(1));
    end
  end

  // Lowest pending due slot.
  always_comb begin
    enc_idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (due_q[i]) enc_idx = IDX_W'(i);
    end
  end

  // Output register.
  assign load = cmd_i.ack_load || cmd_i.emit_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ack_load) begin
      out_matched_q <= 1'b0;
      out_slot_q    <= '0;
      out_last_q    <= 1'b1;
    end else if (cmd_i.emit_en) begin
      out_matched_q <= (due_q != '0);
      out_slot_q    <= (due_q != '0) ? SLOT_W'(enc_idx) : '0;
      out_last_q    <= sts_o.emit_last;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.matched   = out_matched_q;
  assign rsp_o.task_slot = out_slot_q;
  assign rsp_o.last      = out_last_q;
  assign req_i.ready     = cmd_i.in_ready;

  // Status toward the controller.
  always_comb begin
    sts_o.in_valid  = req_i.valid;
    sts_o.op        = req_i.op;
    sts_o.out_free  = !out_vld_q || rsp_o.ready;
    sts_o.scan_done = rd_pend_q && (rd_idx_q == IDX_W'(NUM_ENTRIES - 1));
    sts_o.emit_last = ((due_q & (due_q - NUM_ENTRIES'(1))) == '0);
  end

  // The output register is only loaded when its item has gone or is going.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ack_load || cmd_i.emit_en) |-> (!out_vld_q || rsp_o.ready))
    else $error("output register loaded while full");

  // The table is not written while a scan is running.
  a_no_wr_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_en |-> !(cmd_i.wr_en || cmd_i.clr_en))
    else $error("table changed during scan");

  // A new match starts from an empty due vector and slot zero.
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> (due_q == '0 && cnt_q == '0))
    else $error("scan did not restart cleanly");

  // Every due slot that is emitted belongs to a valid entry.
  a_due_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_en && due_q != '0) |-> ev_q[enc_idx])
    else $error("emitted slot is not valid");

endmodule
